// ===== sv/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg: shared constants for the quaternion vector rotator
// Widths of the datapath, pipeline geometry and register indexes.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int VEC_W   = 32;              // vector component width
    localparam int QUAT_W  = 16;              // quaternion component width
    localparam int PROD_W  = VEC_W + QUAT_W;  // one q*v product
    localparam int SQ_W    = 2 * QUAT_W - 1;  // one q*q square
    localparam int DEN_W   = 2 * QUAT_W + 1;  // squared norm
    localparam int S_W     = 2 * QUAT_W + 1;  // w^2 - u.u
    localparam int SV_W    = S_W + VEC_W;     // s * v
    localparam int DOT2_W  = PROD_W + 3;      // 2 (u.v)
    localparam int CR_W    = PROD_W + 1;      // cross product term
    localparam int W2_W    = QUAT_W + 1;      // 2 w
    localparam int M1_W    = DOT2_W + QUAT_W; // 2 (u.v) u_i
    localparam int M2_W    = W2_W + CR_W;     // 2 w (u x v)_i
    localparam int NUM_W   = M1_W + 2;        // full numerator
    localparam int QB      = VEC_W + 1;       // quotient bits resolved
    localparam int DIV_ST  = QB;              // one quotient bit per stage
    localparam int PRE_ST  = 5;               // stages ahead of the divider
    localparam int PIPE_N  = PRE_ST + DIV_ST + 2;
    localparam int CIDX_W  = 8;

    typedef enum logic [CIDX_W-1:0] {
        CFG_QUAT_W = 8'd0,
        CFG_QUAT_X = 8'd1,
        CFG_QUAT_Y = 8'd2,
        CFG_QUAT_Z = 8'd3
    } cfg_idx_t;

    typedef struct packed {
        logic neg;
        logic ovf;
    } div_tag_t;

endpackage

// ===== sv/quaternion_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate: rotate a vector stream by a set quaternion
//
// Usage: write quat_w/x/y/z through the cfg channel (index 0..3, any other
// index is dropped) while the stream is idle. Each word on s_ carries one
// Q16.16 vector; each word on m_ carries the rotated vector q v q^-1,
// rounded to nearest (ties away from zero) and saturated, with tuser set
// when the quaternion is all zero (vector then zero).
// Throughput: one word per clock unless the receiver stalls. Pipeline: 40
// register stages (5 multiply/sum stages, 33 divider stages of one quotient
// bit each, a rounding stage and the output register).
// The quaternion norm terms are registered from the config registers,
// first as the squares and then as their sums.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// identity quaternion. When the receiver stalls, each stage holds while its
// successor is full and stalled; empty stages still fill, so s_tready stays
// high until every stage holds a word.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate import qvr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CIDX_W-1:0]     cfg_index,
    input  logic [QUAT_W-1:0]     cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [3*VEC_W-1:0]    s_tdata,   // vec_x, vec_y, vec_z
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [3*VEC_W-1:0]    m_tdata,   // rot_x, rot_y, rot_z
    output logic                  m_tuser    // zero_quat_error
);

    // ---------------- configuration ----------------
    logic signed [QUAT_W-1:0] q_reg [4];
    logic [SQ_W-1:0]          sq_reg [4];
    logic [DEN_W-1:0]         n2_reg;
    logic signed [S_W-1:0]    s_reg;
    logic [DEN_W-1:0]         uu_sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg[0] <= QUAT_W'(1 << (QUAT_W - 2));
            q_reg[1] <= '0;
            q_reg[2] <= '0;
            q_reg[3] <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_QUAT_W: q_reg[0] <= cfg_data;
                CFG_QUAT_X: q_reg[1] <= cfg_data;
                CFG_QUAT_Y: q_reg[2] <= cfg_data;
                CFG_QUAT_Z: q_reg[3] <= cfg_data;
                default:    ;
            endcase
        end
    end

    // norm terms, derived from the registers every cycle
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            sq_reg[i] <= SQ_W'((2*QUAT_W)'(q_reg[i]) * (2*QUAT_W)'(q_reg[i]));
        end
    end

    assign uu_sum = DEN_W'(sq_reg[1]) + DEN_W'(sq_reg[2]) + DEN_W'(sq_reg[3]);

    always_ff @(posedge aclk) begin
        n2_reg <= DEN_W'(sq_reg[0]) + uu_sum;
        s_reg  <= S_W'(signed'(DEN_W'(sq_reg[0]) - uu_sum));
    end

    // ---------------- stage handshake ----------------
    logic [PIPE_N-1:0] valid_reg;
    logic [PIPE_N:0]   en;

    always_comb begin
        en[PIPE_N] = m_tready;
        for (int k = PIPE_N - 1; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[PIPE_N-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < PIPE_N; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: products ----------------
    logic signed [VEC_W-1:0]  v_in [3];
    logic signed [PROD_W-1:0] pd_reg [3];   // u_i v_i
    logic signed [PROD_W-1:0] pa_reg [3];   // first cross term
    logic signed [PROD_W-1:0] pb_reg [3];   // second cross term
    logic signed [SV_W-1:0]   sv0_reg [3];

    assign v_in[0] = s_tdata[0*VEC_W +: VEC_W];
    assign v_in[1] = s_tdata[1*VEC_W +: VEC_W];
    assign v_in[2] = s_tdata[2*VEC_W +: VEC_W];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                pd_reg[i]  <= PROD_W'(q_reg[i+1]) * PROD_W'(v_in[i]);
                sv0_reg[i] <= SV_W'(s_reg) * SV_W'(v_in[i]);
            end
            pa_reg[0] <= PROD_W'(q_reg[2]) * PROD_W'(v_in[2]);
            pb_reg[0] <= PROD_W'(q_reg[3]) * PROD_W'(v_in[1]);
            pa_reg[1] <= PROD_W'(q_reg[3]) * PROD_W'(v_in[0]);
            pb_reg[1] <= PROD_W'(q_reg[1]) * PROD_W'(v_in[2]);
            pa_reg[2] <= PROD_W'(q_reg[1]) * PROD_W'(v_in[1]);
            pb_reg[2] <= PROD_W'(q_reg[2]) * PROD_W'(v_in[0]);
        end
    end

    // ---------------- stage 1: dot and cross ----------------
    logic signed [DOT2_W-1:0] dot2_reg;
    logic signed [CR_W-1:0]   cr_reg [3];
    logic signed [SV_W-1:0]   sv1_reg [3];

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            dot2_reg <= (DOT2_W'(pd_reg[0]) + DOT2_W'(pd_reg[1]) + DOT2_W'(pd_reg[2])) <<< 1;
            for (int i = 0; i < 3; i++) begin
                cr_reg[i]  <= CR_W'(pa_reg[i]) - CR_W'(pb_reg[i]);
                sv1_reg[i] <= sv0_reg[i];
            end
        end
    end

    // ---------------- stage 2: second multiplies ----------------
    logic signed [M1_W-1:0] m1_reg [3];
    logic signed [M2_W-1:0] m2_reg [3];
    logic signed [SV_W-1:0] sv2_reg [3];
    logic signed [W2_W-1:0] w2;

    assign w2 = W2_W'(q_reg[0]) <<< 1;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                m1_reg[i]  <= M1_W'(dot2_reg) * M1_W'(q_reg[i+1]);
                m2_reg[i]  <= M2_W'(w2) * M2_W'(cr_reg[i]);
                sv2_reg[i] <= sv1_reg[i];
            end
        end
    end

    // ---------------- stage 3: numerator ----------------
    logic signed [NUM_W-1:0] num_reg [3];

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int i = 0; i < 3; i++) begin
                num_reg[i] <= NUM_W'(sv2_reg[i]) + NUM_W'(m1_reg[i]) + NUM_W'(m2_reg[i]);
            end
        end
    end

    // ---------------- stage 4: magnitude and overflow ----------------
    logic [NUM_W-1:0] mag_reg [3];
    div_tag_t         tag4_reg [3];
    logic [NUM_W-1:0] mag_c [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_c[i] = num_reg[i][NUM_W-1] ? NUM_W'(-num_reg[i]) : NUM_W'(num_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[i]      <= mag_c[i];
                tag4_reg[i].neg <= num_reg[i][NUM_W-1];
                // quotient would need more than QB bits: saturate
                tag4_reg[i].ovf <= ((NUM_W-QB)'(mag_c[i] >> QB) >= (NUM_W-QB)'(n2_reg));
            end
        end
    end

    // ---------------- divider and output ----------------
    logic [QB-1:0]    quo [3];
    logic [DEN_W-1:0] rem [3];
    div_tag_t         tagd [3];
    logic [QB:0]      qr_reg [3];
    div_tag_t         tagr_reg [3];
    logic [VEC_W-1:0] rot_reg [3];
    logic             err_reg;
    logic [QB:0]      lim [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        qvr_div u_div (
            .aclk    (aclk),
            .en      (en[PRE_ST +: DIV_ST]),
            .mag_in  (mag_reg[i]),
            .tag_in  (tag4_reg[i]),
            .den     (n2_reg),
            .quo     (quo[i]),
            .rem     (rem[i]),
            .tag_out (tagd[i])
        );
    end

    // round half away from zero on the magnitude
    always_ff @(posedge aclk) begin
        if (en[PIPE_N-2]) begin
            for (int i = 0; i < 3; i++) begin
                qr_reg[i]   <= (QB+1)'(quo[i])
                             + (QB+1)'({rem[i], 1'b0} >= {1'b0, n2_reg});
                tagr_reg[i] <= tagd[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lim[i] = tagr_reg[i].neg ? (QB+1)'(1) << (VEC_W-1)
                                     : ((QB+1)'(1) << (VEC_W-1)) - (QB+1)'(1);
        end
    end

    // saturate, restore sign, force zero for a zero quaternion
    always_ff @(posedge aclk) begin
        if (en[PIPE_N-1]) begin
            err_reg <= (n2_reg == '0);
            for (int i = 0; i < 3; i++) begin
                if (n2_reg == '0) begin
                    rot_reg[i] <= '0;
                end else if (tagr_reg[i].ovf || qr_reg[i] > lim[i]) begin
                    rot_reg[i] <= tagr_reg[i].neg ? VEC_W'(-lim[i]) : VEC_W'(lim[i]);
                end else begin
                    rot_reg[i] <= tagr_reg[i].neg ? VEC_W'(-qr_reg[i]) : VEC_W'(qr_reg[i]);
                end
            end
        end
    end

    assign m_tdata = {rot_reg[2], rot_reg[1], rot_reg[0]};
    assign m_tuser = err_reg;

endmodule

// ===== sv/qvr_div.sv =====
// ----------------------------------------------------------------------------
// qvr_div: pipelined restoring divider
// Resolves one quotient bit per stage of an unsigned magnitude by the norm.
// ----------------------------------------------------------------------------
module qvr_div import qvr_pkg::*; (
    input  logic              aclk,
    input  logic [DIV_ST-1:0] en,
    input  logic [NUM_W-1:0]  mag_in,
    input  div_tag_t          tag_in,
    input  logic [DEN_W-1:0]  den,
    output logic [QB-1:0]     quo,
    output logic [DEN_W-1:0]  rem,
    output div_tag_t          tag_out
);

    logic [DEN_W-1:0] rem_reg [DIV_ST];
    logic [QB-1:0]    quo_reg [DIV_ST];
    logic [QB-1:0]    low_reg [DIV_ST];
    div_tag_t         tag_reg [DIV_ST];

    for (genvar j = 0; j < DIV_ST; j++) begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [QB-1:0]    quo_in;
        logic [QB-1:0]    low_in;
        div_tag_t         tag_i;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (j == 0) begin : g_first
            assign rem_in = mag_in[QB +: DEN_W];
            assign quo_in = '0;
            assign low_in = mag_in[QB-1:0];
            assign tag_i  = tag_in;
        end else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign low_in = low_reg[j-1];
            assign tag_i  = tag_reg[j-1];
        end

        assign trial = {rem_in, low_in[QB-1]};
        assign diff  = trial - {1'b0, den};
        assign ge    = (trial >= {1'b0, den});

        always_ff @(posedge aclk) begin
            if (en[j]) begin
                rem_reg[j] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_reg[j] <= {quo_in[QB-2:0], ge};
                low_reg[j] <= {low_in[QB-2:0], 1'b0};
                tag_reg[j] <= tag_i;
            end
        end
    end

    assign quo     = quo_reg[DIV_ST-1];
    assign rem     = rem_reg[DIV_ST-1];
    assign tag_out = tag_reg[DIV_ST-1];

endmodule
